// ----- src/wopu_pkg.sv -----
// Shared types, command codes and fixed-point constants for the wheel odometry pose update core.
// Used by the controller, the datapath and the top level; depends on nothing.
package wopu_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 49;
    localparam int CNT_W        = 6;

    localparam logic [3:0] OP_IDLE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CSTEP  = 4'd2;
    localparam logic [3:0] OP_CSAVE  = 4'd3;
    localparam logic [3:0] OP_CINIT  = 4'd4;
    localparam logic [3:0] OP_DSTART = 4'd5;
    localparam logic [3:0] OP_DSTEP  = 4'd6;
    localparam logic [3:0] OP_DEND   = 4'd7;
    localparam logic [3:0] OP_MULA   = 4'd8;
    localparam logic [3:0] OP_ACCX   = 4'd9;
    localparam logic [3:0] OP_MULB   = 4'd10;
    localparam logic [3:0] OP_ACCY   = 4'd11;
    localparam logic [3:0] OP_COMMIT = 4'd12;

    localparam logic [1:0] DSEL_ALPHA = 2'd0;
    localparam logic [1:0] DSEL_MOD   = 2'd1;
    localparam logic [1:0] DSEL_RAD   = 2'd2;

    localparam logic [1:0] CSEL_START = 2'd0;
    localparam logic [1:0] CSEL_END   = 2'd1;

    localparam logic REG_MM_PER_TICK = 1'b0;
    localparam logic REG_WHEEL_BASE  = 1'b1;

    localparam logic [15:0] MM_PER_TICK_RESET = 16'd22872;
    localparam logic [15:0] WHEEL_BASE_RESET  = 16'd2400;

    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [3:0]       op;
        logic [1:0]       sel;
        logic [CNT_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic straight;
        logic out_free;
    } sts_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- src/wopu_ctrl.sv -----
// Controller state machine for the wheel odometry pose update core.
// Depends on wopu_pkg; drives the datapath through wopu_pkg::cmd_t.
module wopu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  wopu_pkg::sts_t      sts,
    output wopu_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CSTEP  = 4'd1;
    localparam logic [3:0] S_CSAVE  = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DSTEP  = 4'd4;
    localparam logic [3:0] S_DEND   = 4'd5;
    localparam logic [3:0] S_CINIT  = 4'd6;
    localparam logic [3:0] S_MULA   = 4'd7;
    localparam logic [3:0] S_ACCX   = 4'd8;
    localparam logic [3:0] S_MULB   = 4'd9;
    localparam logic [3:0] S_ACCY   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]                 state_reg, state_next;
    logic [wopu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       phase_reg, phase_next;
    logic [1:0]                 dsel_reg, dsel_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        dsel_next  = dsel_reg;
        cmd.op     = wopu_pkg::OP_IDLE;
        cmd.sel    = wopu_pkg::CSEL_START;
        cmd.idx    = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = wopu_pkg::OP_LOAD;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    state_next = S_CSTEP;
                end
            end
            S_CSTEP: begin
                cmd.op = wopu_pkg::OP_CSTEP;
                if (cnt_reg == wopu_pkg::CNT_W'(wopu_pkg::CORDIC_STEPS - 1)) begin
                    state_next = S_CSAVE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CSAVE: begin
                cmd.op  = wopu_pkg::OP_CSAVE;
                cmd.sel = phase_reg ? wopu_pkg::CSEL_END : wopu_pkg::CSEL_START;
                if (phase_reg || sts.straight) begin
                    state_next = S_MULA;
                end else begin
                    dsel_next  = wopu_pkg::DSEL_ALPHA;
                    state_next = S_DSTART;
                end
            end
            S_DSTART: begin
                cmd.op     = wopu_pkg::OP_DSTART;
                cmd.sel    = dsel_reg;
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP: begin
                cmd.op = wopu_pkg::OP_DSTEP;
                if (cnt_reg == wopu_pkg::CNT_W'(wopu_pkg::DIV_STEPS - 1)) begin
                    state_next = S_DEND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DEND: begin
                cmd.op  = wopu_pkg::OP_DEND;
                cmd.sel = dsel_reg;
                case (dsel_reg)
                    wopu_pkg::DSEL_ALPHA: begin
                        dsel_next  = wopu_pkg::DSEL_MOD;
                        state_next = S_DSTART;
                    end
                    wopu_pkg::DSEL_MOD: begin
                        dsel_next  = wopu_pkg::DSEL_RAD;
                        state_next = S_DSTART;
                    end
                    default: begin
                        state_next = S_CINIT;
                    end
                endcase
            end
            S_CINIT: begin
                cmd.op     = wopu_pkg::OP_CINIT;
                cnt_next   = '0;
                phase_next = 1'b1;
                state_next = S_CSTEP;
            end
            S_MULA: begin
                cmd.op     = wopu_pkg::OP_MULA;
                state_next = S_ACCX;
            end
            S_ACCX: begin
                cmd.op     = wopu_pkg::OP_ACCX;
                state_next = S_MULB;
            end
            S_MULB: begin
                cmd.op     = wopu_pkg::OP_MULB;
                state_next = S_ACCY;
            end
            S_ACCY: begin
                cmd.op     = wopu_pkg::OP_ACCY;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.op     = wopu_pkg::OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            dsel_reg  <= wopu_pkg::DSEL_ALPHA;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            dsel_reg  <= dsel_next;
        end
    end

endmodule

// ----- src/wopu_datapath.sv -----
// Datapath of the wheel odometry pose update core: pose and configuration registers,
// CORDIC, shared restoring divider, multiplier and output register. Depends on wopu_pkg.
module wopu_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wopu_pkg::cmd_t        cmd,
    output wopu_pkg::sts_t        sts,
    input  logic [31:0]           s_tdata,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata
);

    logic [15:0]        mm_reg, mm_next;
    logic [15:0]        wb_reg, wb_next;
    logic signed [31:0] cur_x_reg, cur_x_next;
    logic signed [31:0] cur_y_reg, cur_y_next;
    logic signed [31:0] cur_h_reg, cur_h_next;
    logic               out_valid_reg, out_valid_next;
    logic [95:0]        out_data_reg, out_data_next;

    logic signed [15:0] l_reg, l_next;
    logic signed [15:0] r_reg, r_next;
    logic [15:0]        w_reg, w_next;
    logic               straight_reg, straight_next;
    logic signed [32:0] d_reg, d_next;

    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [34:0] cz_reg, cz_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] s0_reg, s0_next, c0_reg, c0_next;
    logic signed [33:0] s1_reg, s1_next, c1_reg, c1_next;

    logic [48:0]        dq_reg, dq_next;
    logic [30:0]        dr_reg, dr_next;
    logic [30:0]        den_reg, den_next;
    logic               negq_reg, negq_next;
    logic               negr_reg, negr_next;

    logic signed [49:0] alpha_reg, alpha_next;
    logic signed [31:0] nh_reg, nh_next;
    logic signed [33:0] rad_reg, rad_next;
    logic signed [69:0] prod_reg, prod_next;
    logic signed [31:0] nx_reg, nx_next;
    logic signed [31:0] ny_reg, ny_next;

    logic signed [15:0] in_l, in_r;
    logic [15:0]        w_eff;
    logic signed [16:0] diff;
    logic [15:0]        diff_mag;
    logic signed [34:0] z0, z1, z2;
    logic               flip0;
    logic signed [31:0] init_ang;
    logic signed [33:0] ysh, xsh;
    logic signed [34:0] atan_v;
    logic signed [16:0] dm_a, dm_b;
    logic signed [33:0] dm_p;
    logic signed [49:0] num;
    logic [49:0]        num_mag;
    logic [31:0]        trial_sh;
    logic [32:0]        trial;
    logic signed [49:0] q_s;
    logic signed [31:0] r_s;
    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] acc_t;
    logic signed [70:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [31:0] acc_base;

    assign in_l     = s_tdata[15:0];
    assign in_r     = s_tdata[31:16];
    assign w_eff    = (wb_reg == 16'd0) ? 16'd1 : wb_reg;
    assign diff     = 17'(r_reg) - 17'(l_reg);
    assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];

    assign sts.straight = straight_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    // Angle reduction into the CORDIC's convergence range.
    always_comb begin
        init_ang = (cmd.op == wopu_pkg::OP_LOAD) ? cur_h_reg : nh_reg;
        z0 = 35'(init_ang) <<< 2;
        if (z0 > wopu_pkg::PI_Q30) begin
            z1 = z0 - wopu_pkg::TWO_PI_Q30;
        end else if (z0 < -wopu_pkg::PI_Q30) begin
            z1 = z0 + wopu_pkg::TWO_PI_Q30;
        end else begin
            z1 = z0;
        end
        flip0 = 1'b0;
        z2    = z1;
        if (z1 > wopu_pkg::HALF_PI_Q30) begin
            z2    = z1 - wopu_pkg::PI_Q30;
            flip0 = 1'b1;
        end else if (z1 < -wopu_pkg::HALF_PI_Q30) begin
            z2    = z1 + wopu_pkg::PI_Q30;
            flip0 = 1'b1;
        end
    end

    assign xsh    = cx_reg >>> cmd.idx[4:0];
    assign ysh    = cy_reg >>> cmd.idx[4:0];
    assign atan_v = $signed({3'b000, wopu_pkg::atan_q30(cmd.idx[4:0])});

    // Divider set-up: one multiply, then the dividend and divisor magnitudes.
    always_comb begin
        if (cmd.sel == wopu_pkg::DSEL_ALPHA) begin
            dm_a = diff;
            dm_b = $signed({1'b0, mm_reg});
        end else begin
            dm_a = 17'(l_reg);
            dm_b = $signed({1'b0, w_reg});
        end
        dm_p = dm_a * dm_b;
        case (cmd.sel)
            wopu_pkg::DSEL_ALPHA: num = 50'(dm_p) <<< 16;
            wopu_pkg::DSEL_RAD:   num = 50'(dm_p);
            default:              num = alpha_reg + 50'(cur_h_reg);
        endcase
        num_mag = num[49] ? 50'(-num) : 50'(num);
    end

    assign trial_sh = {1'b0, dr_reg[29:0], dq_reg[48]} | {dr_reg[30], 31'd0};
    assign trial    = {1'b0, trial_sh} - {2'b00, den_reg};
    assign q_s      = negq_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    assign r_s      = negr_reg ? -$signed({1'b0, dr_reg}) : $signed({1'b0, dr_reg});

    always_comb begin
        if (straight_reg) begin
            mul_a = 35'(d_reg);
            mul_b = (cmd.op == wopu_pkg::OP_MULA) ? 35'(c0_reg) : 35'(s0_reg);
        end else begin
            mul_a = 35'(rad_reg);
            mul_b = (cmd.op == wopu_pkg::OP_MULA) ? 35'(s1_reg) - 35'(s0_reg)
                                                  : 35'(c0_reg) - 35'(c1_reg);
        end
    end

    always_comb begin
        if (straight_reg) begin
            acc_t = (prod_reg + 70'sd2199023255552) >>> 42;
        end else begin
            acc_t = (prod_reg + 70'sd536870912) >>> 30;
        end
        acc_base = (cmd.op == wopu_pkg::OP_ACCX) ? cur_x_reg : cur_y_reg;
        acc_sum  = 71'(acc_base) + 71'(acc_t);
        if (acc_sum > 71'sd2147483647) begin
            acc_sat = 32'sh7FFFFFFF;
        end else if (acc_sum < -71'sd2147483648) begin
            acc_sat = 32'sh80000000;
        end else begin
            acc_sat = acc_sum[31:0];
        end
    end

    always_comb begin
        mm_next        = mm_reg;
        wb_next        = wb_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_h_next     = cur_h_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        straight_next  = straight_reg;
        d_next         = d_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        s0_next        = s0_reg;
        c0_next        = c0_reg;
        s1_next        = s1_reg;
        c1_next        = c1_reg;
        dq_next        = dq_reg;
        dr_next        = dr_reg;
        den_next       = den_reg;
        negq_next      = negq_reg;
        negr_next      = negr_reg;
        alpha_next     = alpha_reg;
        nh_next        = nh_reg;
        rad_next       = rad_reg;
        prod_next      = prod_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                wopu_pkg::REG_MM_PER_TICK: mm_next = cfg_wdata;
                wopu_pkg::REG_WHEEL_BASE:  wb_next = cfg_wdata;
                default: ;
            endcase
        end

        case (cmd.op)
            wopu_pkg::OP_LOAD, wopu_pkg::OP_CINIT: begin
                if (cmd.op == wopu_pkg::OP_LOAD) begin
                    l_next        = in_l;
                    r_next        = in_r;
                    w_next        = w_eff;
                    straight_next = (in_l == in_r);
                    d_next        = 33'(in_l) * 33'($signed({1'b0, mm_reg}));
                    nh_next       = cur_h_reg;
                end
                cx_next   = wopu_pkg::CORDIC_GAIN;
                cy_next   = '0;
                cz_next   = z2;
                flip_next = flip0;
            end
            wopu_pkg::OP_CSTEP: begin
                if (!cz_reg[34]) begin
                    cx_next = cx_reg - ysh;
                    cy_next = cy_reg + xsh;
                    cz_next = cz_reg - atan_v;
                end else begin
                    cx_next = cx_reg + ysh;
                    cy_next = cy_reg - xsh;
                    cz_next = cz_reg + atan_v;
                end
            end
            wopu_pkg::OP_CSAVE: begin
                if (cmd.sel == wopu_pkg::CSEL_END) begin
                    s1_next = flip_reg ? -cy_reg : cy_reg;
                    c1_next = flip_reg ? -cx_reg : cx_reg;
                end else begin
                    s0_next = flip_reg ? -cy_reg : cy_reg;
                    c0_next = flip_reg ? -cx_reg : cx_reg;
                end
            end
            wopu_pkg::OP_DSTART: begin
                dq_next   = num_mag[48:0];
                dr_next   = '0;
                negr_next = num[49];
                case (cmd.sel)
                    wopu_pkg::DSEL_ALPHA: begin
                        den_next  = 31'(w_reg);
                        negq_next = num[49];
                    end
                    wopu_pkg::DSEL_RAD: begin
                        den_next  = 31'(diff_mag);
                        negq_next = num[49] ^ diff[16];
                    end
                    default: begin
                        den_next  = wopu_pkg::TWO_PI_Q28[30:0];
                        negq_next = num[49];
                    end
                endcase
            end
            wopu_pkg::OP_DSTEP: begin
                if (!trial[32]) begin
                    dr_next = trial[30:0];
                    dq_next = {dq_reg[47:0], 1'b1};
                end else begin
                    dr_next = trial_sh[30:0];
                    dq_next = {dq_reg[47:0], 1'b0};
                end
            end
            wopu_pkg::OP_DEND: begin
                case (cmd.sel)
                    wopu_pkg::DSEL_ALPHA: alpha_next = q_s;
                    wopu_pkg::DSEL_MOD:   nh_next    = r_s;
                    default:              rad_next   = q_s[33:0] + 34'(w_reg >> 1);
                endcase
            end
            wopu_pkg::OP_MULA, wopu_pkg::OP_MULB: begin
                prod_next = mul_a * mul_b;
            end
            wopu_pkg::OP_ACCX: begin
                nx_next = acc_sat;
            end
            wopu_pkg::OP_ACCY: begin
                ny_next = acc_sat;
            end
            wopu_pkg::OP_COMMIT: begin
                cur_x_next     = nx_reg;
                cur_y_next     = ny_reg;
                cur_h_next     = nh_reg;
                out_valid_next = 1'b1;
                out_data_next  = {nh_reg, ny_reg, nx_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_reg        <= wopu_pkg::MM_PER_TICK_RESET;
            wb_reg        <= wopu_pkg::WHEEL_BASE_RESET;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_h_reg     <= '0;
            out_valid_reg <= 1'b0;
            straight_reg  <= 1'b0;
        end else begin
            mm_reg        <= mm_next;
            wb_reg        <= wb_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cur_h_reg     <= cur_h_next;
            out_valid_reg <= out_valid_next;
            straight_reg  <= straight_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        w_reg        <= w_next;
        d_reg        <= d_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        flip_reg     <= flip_next;
        s0_reg       <= s0_next;
        c0_reg       <= c0_next;
        s1_reg       <= s1_next;
        c1_reg       <= c1_next;
        dq_reg       <= dq_next;
        dr_reg       <= dr_next;
        den_reg      <= den_next;
        negq_reg     <= negq_next;
        negr_reg     <= negr_next;
        alpha_reg    <= alpha_next;
        nh_reg       <= nh_next;
        rad_reg      <= rad_next;
        prod_reg     <= prod_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
    end

endmodule

// ----- src/wheel_odometry_pose_update_core.sv -----
// Top level of the differential-drive odometry pose update core.
// Depends on wopu_pkg, wopu_ctrl and wopu_datapath.
//
//   Channel   Direction  Contents
//   s_        in         one item: left and right encoder tick deltas
//   m_        out        one item per input: new x, y and heading
//   cfg_      in         register writes: mm_per_tick, wheel_base
//
// A straight move runs the 30-step CORDIC once; a turn runs it twice and the 49-step
// divider three times. One item is worked on at a time; the next is accepted the cycle
// after the result enters the output register.
// A result still held in the output register stalls the next commit until it is taken.
// Reset is synchronous and active low and returns the pose to zero.
module wheel_odometry_pose_update_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_ticks, right_ticks
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pose_x, pose_y, pose_heading
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    wopu_pkg::cmd_t cmd;
    wopu_pkg::sts_t sts;

    wopu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wopu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTH
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[95:64]) < wopu_pkg::TWO_PI_Q28 &&
                      $signed(m_tdata[95:64]) > -wopu_pkg::TWO_PI_Q28))
        else $error("heading outside one turn");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while busy");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ----- verif/wheel_odometry_pose_update_core_tb.sv -----
// Self-checking testbench for the wheel odometry pose update core: directed and random
// encoder tick pairs under several register settings and idling phases.
// Depends on wopu_pkg and wheel_odometry_pose_update_core.
module wheel_odometry_pose_update_core_tb;

    localparam longint TWO_PI28 = 64'sd1686629713;
    localparam longint PI30 = 64'sd3373259426;
    localparam longint TWO_PI30 = 64'sd6746518852;
    localparam longint HALF_PI30 = 64'sd1686629713;
    localparam longint GAIN30 = 64'sd652032874;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_OFF_LEN = 1500;

    typedef struct packed {
        logic signed [15:0] right_ticks;
        logic signed [15:0] left_ticks;
    } ticks_t;

    typedef struct packed {
        logic signed [31:0] heading;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    ticks_t pending_ticks[$];
    pose_t  expected_poses[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off_armed = 1'b0;
    bit     hold_off_done = 1'b0;
    int     hold_off_count = 0;
    int     quiet_cycles;
    int     error_count = 0;
    logic [15:0] mm_per_tick_q;
    logic [15:0] wheel_base_q;
    longint pose_x_q = 0;
    longint pose_y_q = 0;
    longint heading_q = 0;

    wheel_odometry_pose_update_core DUT (.*);

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        longint t [30] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};
        return t[i];
    endfunction

    task automatic rotate_unit(input longint ang28, output longint sin30, output longint cos30);
        longint z, cx, cy, nx;
        bit flip;
        z = (ang28 % TWO_PI28) * 4;
        cx = GAIN30;
        cy = 0;
        flip = 0;
        if (z > PI30) z -= TWO_PI30;
        if (z < -PI30) z += TWO_PI30;
        if (z > HALF_PI30) begin
            z -= PI30;
            flip = 1;
        end else if (z < -HALF_PI30) begin
            z += PI30;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = cx - floor_shift(cy, i);
                cy = cy + floor_shift(cx, i);
                z -= atan_entry(i);
            end else begin
                nx = cx + floor_shift(cy, i);
                cy = cy - floor_shift(cx, i);
                z += atan_entry(i);
            end
            cx = nx;
        end
        sin30 = flip ? -cy : cy;
        cos30 = flip ? -cx : cx;
    endtask

    task automatic advance_pose(input ticks_t t);
        longint l, r, m, w, s0, c0, s1, c1, d, alpha, rad, nh;
        pose_t p;
        l = t.left_ticks;
        r = t.right_ticks;
        m = mm_per_tick_q;
        w = (wheel_base_q == 0) ? 1 : wheel_base_q;
        rotate_unit(heading_q, s0, c0);
        if (l == r) begin
            d = l * m;
            pose_x_q = clamp32(pose_x_q + floor_shift(d * c0 + (64'sd1 <<< 41), 42));
            pose_y_q = clamp32(pose_y_q + floor_shift(d * s0 + (64'sd1 <<< 41), 42));
        end else begin
            alpha = ((r - l) * m * 65536) / w;
            rad = (l * w) / (r - l) + (w >>> 1);
            nh = (heading_q + alpha) % TWO_PI28;
            rotate_unit(nh, s1, c1);
            pose_x_q = clamp32(pose_x_q + floor_shift(rad * (s1 - s0) + (64'sd1 <<< 29), 30));
            pose_y_q = clamp32(pose_y_q + floor_shift(rad * (c0 - c1) + (64'sd1 <<< 29), 30));
            heading_q = nh;
        end
        p.x = pose_x_q[31:0];
        p.y = pose_y_q[31:0];
        p.heading = heading_q[31:0];
        expected_poses = {expected_poses, p};
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata <= pending_ticks[0];
                advance_pose(pending_ticks.pop_front());
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_off_armed && !hold_off_done) begin
            m_tready <= 0;
            if (hold_off_count >= HOLD_OFF_LEN - 1) hold_off_done <= 1'b1;
            hold_off_count <= hold_off_count + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pose_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_poses.size() == 0) begin
                $error("Unexpected result item %h", m_tdata);
                error_count++;
            end else begin
                want = expected_poses.pop_front();
                if (got.x !== want.x) begin
                    $error("pose_x expected %0d got %0d", want.x, got.x);
                    error_count++;
                end
                if (got.y !== want.y) begin
                    $error("pose_y expected %0d got %0d", want.y, got.y);
                    error_count++;
                end
                if (got.heading !== want.heading) begin
                    $error("pose_heading expected %0d got %0d", want.heading, got.heading);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("wheel_odometry_pose_update_core verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1;
        @(posedge aclk);
        cfg_wr_en <= 0;
        if (idx == wopu_pkg::REG_MM_PER_TICK) mm_per_tick_q = value;
        else wheel_base_q = value;
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || expected_poses.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    function automatic ticks_t make_pair(int l, int r);
        ticks_t t;
        t.left_ticks = 16'(l);
        t.right_ticks = 16'(r);
        return t;
    endfunction

    task automatic queue_pair(input ticks_t t);
        pending_ticks = {pending_ticks, t};
    endtask

    task automatic queue_random(int count);
        int l, k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(9);
            l = $urandom_range(65535) - 32768;
            if (k < 3) queue_pair(make_pair(l, l));
            else if (k < 7)
                queue_pair(make_pair($urandom_range(200) - 100,
                                     $urandom_range(200) - 100));
            else queue_pair(make_pair(l, $urandom_range(65535) - 32768));
        end
    endtask

    initial begin
        int phase_idle [4] = '{0, 54, 0, 11};
        int phase_stall [4] = '{0, 0, 54, 11};
        logic [15:0] mm_set [4] = '{16'd1, 16'd65535, 16'd22872, 16'd5000};
        logic [15:0] wb_set [4] = '{16'd16, 16'd65535, 16'd2400, 16'd700};
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_index = wopu_pkg::REG_MM_PER_TICK;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mm_per_tick_q = wopu_pkg::MM_PER_TICK_RESET;
        wheel_base_q = wopu_pkg::WHEEL_BASE_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        queue_pair(make_pair(0, 0));
        queue_pair(make_pair(100, 100));
        queue_pair(make_pair(-100, -100));
        queue_pair(make_pair(32767, 32767));
        queue_pair(make_pair(-32768, -32768));
        queue_pair(make_pair(0, 50));
        queue_pair(make_pair(50, 0));
        queue_pair(make_pair(-32768, 32767));
        queue_pair(make_pair(32767, -32768));
        queue_pair(make_pair(-1, 0));
        queue_pair(make_pair(10, 11));
        for (int i = 0; i < 8; i++) queue_pair(make_pair(32767, 32767));
        queue_pair(make_pair(-5, 300));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(wopu_pkg::REG_MM_PER_TICK, mm_set[ph]);
            write_reg(wopu_pkg::REG_WHEEL_BASE, wb_set[ph]);
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            if (ph == 0) hold_off_armed = 1'b1;
            queue_random(240);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        if (error_count == 0) begin
            $display("wheel_odometry_pose_update_core verification clean");
        end else begin
            $display("wheel_odometry_pose_update_core verification failed");
        end
        $finish;
    end
endmodule

// ----- wheel_odometry_pose_update_core.f -----
src/wopu_pkg.sv
src/wopu_ctrl.sv
src/wopu_datapath.sv
src/wheel_odometry_pose_update_core.sv
verif/wheel_odometry_pose_update_core_tb.sv
